// ----- hdl/necir_pkg.sv -----
// Package: event codes, pulse width windows and register map for the NEC IR decoder.
`timescale 1ns / 1ps
`default_nettype none
package necir_pkg;

   // Event codes carried on req_type
   typedef enum logic [1:0] {
      EV_IDLE_TICK = 2'd0,
      EV_RISE      = 2'd1,
      EV_FALL      = 2'd2,
      EV_READ_KEY  = 2'd3
   } event_type;

   localparam int unsigned WIDTH_W = 16;
   localparam int unsigned FRAME_W = 32;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TICK_W  = 4;

   // Pulse width windows in us, exclusive bounds
   localparam logic [WIDTH_W-1:0] BIT0_LO   = 16'd300;
   localparam logic [WIDTH_W-1:0] BIT0_HI   = 16'd800;
   localparam logic [WIDTH_W-1:0] BIT1_LO   = 16'd1400;
   localparam logic [WIDTH_W-1:0] BIT1_HI   = 16'd1800;
   localparam logic [WIDTH_W-1:0] LEAD_LO   = 16'd4200;
   localparam logic [WIDTH_W-1:0] LEAD_HI   = 16'd4700;
   localparam logic [WIDTH_W-1:0] REPEAT_LO = 16'd2200;
   localparam logic [WIDTH_W-1:0] REPEAT_HI = 16'd2600;

   localparam logic [TICK_W-1:0] IDLE_LIMIT_RESET = 4'd14;

   // Register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   typedef enum logic [0:0] {
      REG_IDLE_TICK_LIMIT = 1'b0
   } reg_index_type;

endpackage
`default_nettype wire

// ----- hdl/nec_ir_pulse_decoder.sv -----
// NEC infrared remote decoder: event-driven state machine with registered result.
//
// Usage:
//  - Input channel (req_*): one event per transfer. req_type selects idle tick,
//    rising edge, falling edge (req_high_width_us holds the measured high width)
//    or key read. A transfer happens on a rising clock edge with req_valid high
//    and req_stall low.
//  - Result channel (rsp_*): exactly one result per event, in order: the key
//    byte on a valid read (else 0), a frame-done flag, the repeat count and the
//    receiving flag, all as they stand after the event.
//  - CSR port (csr_*): APB style, always ready. Byte address 0 holds
//    idle_tick_limit (4 bits, reset 14). Write only while the block is idle.
// Output: the result is registered and shows in the cycle after the input
// transfer. Throughput: one event per cycle while req_stall is low; the decode
// is a handful of width compares and a 32-bit shift into the frame register.
// Stall: req_stall is raised only while a result sits in the output register
// and the receiver stalls it, so a new event is taken in the same cycle the
// waiting result is transferred.
// Reset (synchronous, active high) clears the decoder state, empties the output
// register and restores idle_tick_limit to 14.
`timescale 1ns / 1ps
`default_nettype none
module nec_ir_pulse_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // event input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_type,
   input  wire logic [necir_pkg::WIDTH_W-1:0]     req_high_width_us,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [necir_pkg::BYTE_W-1:0]           rsp_key_code,
   output logic                                   rsp_frame_done,
   output logic [necir_pkg::BYTE_W-1:0]           rsp_repeat_count,
   output logic                                   rsp_receiving,
   // CSR port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [necir_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [necir_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [necir_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   // decoder state
   logic                              started_ff, started_in;
   logic                              frame_ready_ff, frame_ready_in;
   logic                              rise_seen_ff, rise_seen_in;
   logic [necir_pkg::TICK_W-1:0]      idle_ticks_ff, idle_ticks_in;
   logic [necir_pkg::FRAME_W-1:0]     frame_bits_ff, frame_bits_in;
   logic [necir_pkg::BYTE_W-1:0]      repeats_ff, repeats_in;
   logic [necir_pkg::TICK_W-1:0]      idle_limit_ff;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [necir_pkg::BYTE_W-1:0]      key_ff;
   logic                              done_ff;
   logic [necir_pkg::BYTE_W-1:0]      rep_ff;
   logic                              recv_ff;

   logic                              accept;
   logic [necir_pkg::BYTE_W-1:0]      key_in;
   logic                              done_in;
   logic                              is_bit0, is_bit1, is_lead, is_repeat;
   logic                              frame_ok;
   logic                              csr_wr;
   necir_pkg::event_type              ev;

   // --- handshake: output register empties or drains this cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign ev        = necir_pkg::event_type'(req_type);

   // --- width classification
   assign is_bit0   = (req_high_width_us > necir_pkg::BIT0_LO) &&
                      (req_high_width_us < necir_pkg::BIT0_HI);
   assign is_bit1   = (req_high_width_us > necir_pkg::BIT1_LO) &&
                      (req_high_width_us < necir_pkg::BIT1_HI);
   assign is_lead   = (req_high_width_us > necir_pkg::LEAD_LO) &&
                      (req_high_width_us < necir_pkg::LEAD_HI);
   assign is_repeat = (req_high_width_us > necir_pkg::REPEAT_LO) &&
                      (req_high_width_us < necir_pkg::REPEAT_HI);

   // frame layout: address, ~address, command, ~command (MSB first)
   assign frame_ok = (frame_bits_ff[31:24] == 8'h00) &&
                     (frame_bits_ff[23:16] == 8'hFF) &&
                     (frame_bits_ff[15:8]  == ~frame_bits_ff[7:0]);

   // --- next state and result
   always_comb begin
      started_in     = started_ff;
      frame_ready_in = frame_ready_ff;
      rise_seen_in   = rise_seen_ff;
      idle_ticks_in  = idle_ticks_ff;
      frame_bits_in  = frame_bits_ff;
      repeats_in     = repeats_ff;
      key_in         = '0;
      done_in        = 1'b0;
      case (ev)
         necir_pkg::EV_IDLE_TICK: begin
            if (started_ff) begin
               rise_seen_in = 1'b0;
               // first tick after the start closes the frame
               if (idle_ticks_ff == '0) begin
                  frame_ready_in = 1'b1;
                  done_in        = 1'b1;
               end
               if (idle_ticks_ff < idle_limit_ff) begin
                  idle_ticks_in = idle_ticks_ff + 1'b1;
               end else begin
                  started_in    = 1'b0;
                  idle_ticks_in = '0;
               end
            end
         end
         necir_pkg::EV_RISE: begin
            rise_seen_in = 1'b1;
         end
         necir_pkg::EV_FALL: begin
            if (rise_seen_ff) begin
               if (started_ff) begin
                  if (is_bit0) begin
                     frame_bits_in = {frame_bits_ff[necir_pkg::FRAME_W-2:0], 1'b0};
                  end else if (is_bit1) begin
                     frame_bits_in = {frame_bits_ff[necir_pkg::FRAME_W-2:0], 1'b1};
                  end
               end else if (is_lead) begin
                  started_in = 1'b1;
                  repeats_in = '0;
               end else if (is_repeat) begin
                  repeats_in = repeats_ff + 1'b1;   // wraps
               end
               rise_seen_in = 1'b0;
            end
         end
         necir_pkg::EV_READ_KEY: begin
            if (frame_ready_ff) begin
               if (frame_ok) begin
                  key_in = frame_bits_ff[15:8];
               end
               frame_ready_in = 1'b0;
               repeats_in     = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // --- state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         frame_ready_ff <= 1'b0;
         rise_seen_ff   <= 1'b0;
         idle_ticks_ff  <= '0;
         frame_bits_ff  <= '0;
         repeats_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            started_ff     <= started_in;
            frame_ready_ff <= frame_ready_in;
            rise_seen_ff   <= rise_seen_in;
            idle_ticks_ff  <= idle_ticks_in;
            frame_bits_ff  <= frame_bits_in;
            repeats_ff     <= repeats_in;
         end
      end
   end

   // --- result payload, loaded on each input transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= key_in;
         done_ff <= done_in;
         rep_ff  <= repeats_in;
         recv_ff <= started_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_code     = key_ff;
   assign rsp_frame_done   = done_ff;
   assign rsp_repeat_count = rep_ff;
   assign rsp_receiving    = recv_ff;

   // --- CSR port; word address taken from paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= necir_pkg::IDLE_LIMIT_RESET;
      end else if (csr_wr &&
                   (necir_pkg::reg_index_type'(csr_paddr[2]) ==
                    necir_pkg::REG_IDLE_TICK_LIMIT)) begin
         idle_limit_ff <= csr_pwdata[necir_pkg::TICK_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (necir_pkg::reg_index_type'(csr_paddr[2]) == necir_pkg::REG_IDLE_TICK_LIMIT) begin
         csr_prdata[necir_pkg::TICK_W-1:0] = idle_limit_ff;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/necir_checker.sv -----
// Port-level checker for the NEC IR decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module necir_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [necir_pkg::BYTE_W-1:0]  rsp_key_code,
   input wire logic                          rsp_frame_done,
   input wire logic [necir_pkg::BYTE_W-1:0]  rsp_repeat_count
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_code) &&
                                 $stable(rsp_repeat_count))
      else $error("stalled result changed");

   // stall toward the sender only when a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // every new result follows an input transfer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without input transfer");

   // a delivered key comes from a read, which clears repeats and marks no frame
   a_key_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_key_code != '0) |-> (rsp_repeat_count == '0) && !rsp_frame_done)
      else $error("key result inconsistent");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind nec_ir_pulse_decoder necir_checker u_necir_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_key_code     (rsp_key_code),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_repeat_count (rsp_repeat_count)
);
`default_nettype wire
